>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(name, ante, cons)
`define ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> sv/bld_pkg.sv
// ----------------------------------------------------------------------------
// bld_pkg
// Shared types and constants of the bounded list deque.
// ----------------------------------------------------------------------------
package bld_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 48;
    localparam int VOUT_W     = 32;
    localparam int CNT_OUT_W  = 5;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_REM_FRONT = 3'd2,
        CMD_REM_BACK  = 3'd3,
        CMD_REM_VAL   = 3'd4
    } bld_cmd_t;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic shift_r;
        logic shift_l;
        logic load_en;
    } bld_ctrl_t;

endpackage

>>> sv/bld_cell.sv
// ----------------------------------------------------------------------------
// bld_cell
// One list entry: loads, takes its left or right neighbor, or holds its value.
// ----------------------------------------------------------------------------
module bld_cell
    import bld_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int IDX         = 0
)
(
    input  logic                              clk,
    input  bld_ctrl_t                         ctrl,
    input  logic [$clog2(CAPACITY + 1) - 1:0] load_pos,
    input  logic [VALUE_WIDTH - 1:0]          load_data,
    input  logic [VALUE_WIDTH - 1:0]          left_data,
    input  logic [VALUE_WIDTH - 1:0]          right_data,
    output logic [VALUE_WIDTH - 1:0]          data
);

    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam logic [CNTW - 1:0] IDX_C = CNTW'(IDX);

    logic [VALUE_WIDTH - 1:0] data_reg;
    logic [VALUE_WIDTH - 1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load_en && (load_pos == IDX_C))
        begin
            data_next = load_data;
        end
        else if (ctrl.shift_r)
        begin
            data_next = left_data;
        end
        else if (ctrl.shift_l)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> sv/bounded_list_deque_core.sv
// ----------------------------------------------------------------------------
// bounded_list_deque_core
// Bounded deque with remove-by-value, held in a row of shifting entry cells.
// Result: registered on the edge that takes an end insert/removal; for a
//   remove-by-value on a non-empty list, registered as the ST_WALK rotation ends.
// Throughput: one end insert/removal per cycle while m_tready stays high;
//   remove-by-value on a non-empty list holds the input while the entries rotate.
// Reset: rst_n asynchronous, active low; empties the list, clears handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_list_deque_core
    import bld_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_W - 1:0]    s_tdata,   // value[31:0]
    input  logic [IN_USER_W - 1:0]    s_tuser,   // command[2:0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_W - 1:0]   m_tdata    // value_out[31:0], status[33:32],
                                                 // entry_count[38:34], is_empty[39],
                                                 // removed_count[44:40], zero[47:45]
);

    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam logic [CNTW - 1:0] CAP_C = CNTW'(CAPACITY);

    typedef enum logic {ST_IDLE, ST_WALK} state_t;

    state_t                   state_reg,   state_next;
    logic [CNTW - 1:0]        count_reg,   count_next;
    logic [CNTW - 1:0]        steps_reg,   steps_next;
    logic [CNTW - 1:0]        len_reg,     len_next;
    logic [CNTW - 1:0]        had_reg,     had_next;
    logic [VALUE_WIDTH - 1:0] match_reg,   match_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W - 1:0]  m_tdata_reg,  m_tdata_next;

    bld_ctrl_t                ctrl;
    logic [CNTW - 1:0]        load_pos;
    logic [VALUE_WIDTH - 1:0] load_data;
    logic [VALUE_WIDTH - 1:0] cell_q [CAPACITY];
    logic [VALUE_WIDTH - 1:0] tail;
    logic [VALUE_WIDTH - 1:0] v_in;
    logic                     accept;
    logic                     keep;

    logic                     res_load;
    logic [VALUE_WIDTH - 1:0] res_vout;
    logic [1:0]               res_status;
    logic [CNTW - 1:0]        res_removed;
    logic [VALUE_WIDTH + VOUT_W - 1:0] vout_wide;
    logic [CNTW + CNT_OUT_W - 1:0]     cnt_wide;
    logic [CNTW + CNT_OUT_W - 1:0]     rem_wide;

    assign v_in     = VALUE_WIDTH'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // cell row, front at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_WIDTH - 1:0] left_d;
        logic [VALUE_WIDTH - 1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_q[i - 1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_q[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_q[i + 1];
        end

        bld_cell #(
            .CAPACITY    (CAPACITY),
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX         (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .load_pos   (load_pos),
            .load_data  (load_data),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_q[i])
        );
    end

    always_comb
    begin
        tail = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (count_reg == CNTW'(i + 1))
            begin
                tail = tail | cell_q[i];
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        steps_next    = steps_reg;
        len_next      = len_reg;
        had_next      = had_reg;
        match_next    = match_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        ctrl        = '0;
        load_pos    = '0;
        load_data   = v_in;
        keep        = 1'b0;
        res_load    = 1'b0;
        res_vout    = '0;
        res_status  = STAT_OK;
        res_removed = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_load = 1'b1;
                    case (bld_cmd_t'(s_tuser))
                        CMD_INS_FRONT:
                        begin
                            if (count_reg == CAP_C)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                ctrl.shift_r = 1'b1;
                                ctrl.load_en = 1'b1;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        CMD_INS_BACK:
                        begin
                            if (count_reg == CAP_C)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                ctrl.load_en = 1'b1;
                                load_pos     = count_reg;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        CMD_REM_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                res_vout     = cell_q[0];
                                res_removed  = CNTW'(1);
                                ctrl.shift_l = 1'b1;
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        CMD_REM_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                res_vout    = tail;
                                res_removed = CNTW'(1);
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        CMD_REM_VAL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                res_load   = 1'b0;
                                state_next = ST_WALK;
                                steps_next = count_reg;
                                len_next   = count_reg;
                                had_next   = count_reg;
                                match_next = v_in;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // rotate the head to the ring tail if kept, else shrink the ring
                keep         = (cell_q[0] != match_reg);
                ctrl.shift_l = 1'b1;
                ctrl.load_en = keep;
                load_pos     = len_reg - 1'b1;
                load_data    = cell_q[0];
                len_next     = keep ? len_reg : len_reg - 1'b1;
                steps_next   = steps_reg - 1'b1;
                if (steps_reg == CNTW'(1))
                begin
                    state_next  = ST_IDLE;
                    count_next  = len_next;
                    res_load    = 1'b1;
                    res_removed = had_reg - len_next;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        vout_wide = (VALUE_WIDTH + VOUT_W)'(res_vout);
        cnt_wide  = (CNTW + CNT_OUT_W)'(count_next);
        rem_wide  = (CNTW + CNT_OUT_W)'(res_removed);

        if (res_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000,
                             rem_wide[CNT_OUT_W - 1:0],
                             (count_next == '0),
                             cnt_wide[CNT_OUT_W - 1:0],
                             res_status,
                             vout_wide[VOUT_W - 1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            steps_reg    <= '0;
            len_reg      <= '0;
            had_reg      <= '0;
            match_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            steps_reg    <= steps_next;
            len_reg      <= len_next;
            had_reg      <= had_next;
            match_reg    <= match_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    `ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CAP_C)
    `ASSERT_IMPL(a_walk_no_accept, state_reg == ST_WALK, !s_tready)
    `ASSERT_IMPL(a_walk_ring, state_reg == ST_WALK, (len_reg >= steps_reg) && (had_reg >= len_reg) && (steps_reg != '0))
    `ASSERT_NEXT(a_accept_resp, accept, m_tvalid || (state_reg == ST_WALK))

endmodule

>>> tb/bounded_list_deque_core_tb.sv
// ----------------------------------------------------------------------------
// bounded_list_deque_core_tb
// Self-checking bench for the bounded deque. A directed pass hits the empty,
// full, head-match and reserved-command cases. Randomized phases then follow:
// insert-heavy, balanced and remove-heavy command mixes, with values drawn
// mostly from a small pool so remove-by-value finds matches. A scoreboard
// keeps its own copy of the list, predicts each result word and compares it
// field by field. Both stream sides idle at random, except in one long stretch.
// ----------------------------------------------------------------------------
module bounded_list_deque_core_tb;
    import bld_pkg::*;

    localparam int         DEPTH          = CAPACITY_DEF;
    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;
    localparam int         IDLE_PCT       = 29;
    localparam int         PHASES         = 11;
    localparam int         PHASE_WORDS    = 98;

    typedef struct packed {
        logic [31:0] value_out;
        logic [1:0]  status;
        logic [4:0]  entry_count;
        logic        is_empty;
        logic [4:0]  removed_count;
    } deque_result_t;

    class deque_scoreboard;
        logic [31:0]   contents[$];
        deque_result_t results_due[$];
        int            errors;
        int            cmd_count[8];
        int            full_hits;
        int            empty_hits;
        int            multi_removals;

        function new();
            errors         = 0;
            full_hits      = 0;
            empty_hits     = 0;
            multi_removals = 0;
            foreach (cmd_count[i])
                cmd_count[i] = 0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void note_word(logic [2:0] cmd, logic [31:0] val);
            deque_result_t want;
            logic [31:0]   kept[$];
            want        = '0;
            want.status = STAT_OK;
            cmd_count[cmd]++;
            case (cmd)
                CMD_INS_FRONT, CMD_INS_BACK:
                begin
                    if (contents.size() >= DEPTH)
                    begin
                        want.status = STAT_FULL;
                        full_hits++;
                    end
                    else if (cmd == CMD_INS_FRONT)
                        contents.push_front(val);
                    else
                        contents.push_back(val);
                end
                CMD_REM_FRONT, CMD_REM_BACK:
                begin
                    if (contents.size() == 0)
                    begin
                        want.status = STAT_EMPTY;
                        empty_hits++;
                    end
                    else
                    begin
                        want.value_out     = (cmd == CMD_REM_FRONT) ? contents.pop_front()
                                                                    : contents.pop_back();
                        want.removed_count = 5'd1;
                    end
                end
                CMD_REM_VAL:
                begin
                    if (contents.size() == 0)
                    begin
                        want.status = STAT_EMPTY;
                        empty_hits++;
                    end
                    else
                    begin
                        foreach (contents[i])
                            if (contents[i] != val)
                                kept.push_back(contents[i]);
                        want.removed_count = 5'(contents.size() - kept.size());
                        if (want.removed_count > 1)
                            multi_removals++;
                        contents = kept;
                    end
                end
                default:
                begin
                end
            endcase
            want.entry_count = 5'(contents.size());
            want.is_empty    = (contents.size() == 0);
            results_due.push_back(want);
        endfunction

        function void mismatch(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10)
                $display("MISMATCH %s: expected 0x%08h, got 0x%08h", field, want, got);
        endfunction

        function void check_word(logic [OUT_DATA_W - 1:0] word);
            deque_result_t got;
            deque_result_t want;
            got.value_out     = word[31:0];
            got.status        = word[33:32];
            got.entry_count   = word[38:34];
            got.is_empty      = word[39];
            got.removed_count = word[44:40];
            if (results_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("MISMATCH: result word 0x%012h with none outstanding", word);
                return;
            end
            want = results_due.pop_front();
            if (got.value_out !== want.value_out)
                mismatch("value_out", want.value_out, got.value_out);
            if (got.status !== want.status)
                mismatch("status", 32'(want.status), 32'(got.status));
            if (got.entry_count !== want.entry_count)
                mismatch("entry_count", 32'(want.entry_count), 32'(got.entry_count));
            if (got.is_empty !== want.is_empty)
                mismatch("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            if (got.removed_count !== want.removed_count)
                mismatch("removed_count", 32'(want.removed_count), 32'(got.removed_count));
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W - 1:0]  s_tdata;
    logic [IN_USER_W - 1:0]  s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W - 1:0] m_tdata;

    logic                    idle_en;
    logic [31:0]             value_pool[4];
    deque_scoreboard         sb = new();

    bounded_list_deque_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
        m_tready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);

    // handshake signals only move at posedge, so the negedge view is the accepted word
    always @(negedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata);

    task automatic send_word(input logic [2:0] cmd, input logic [31:0] val);
        while (idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        sb.note_word(cmd, val);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_word(input int ins_pct);
        logic [2:0]  cmd;
        logic [31:0] val;
        int          r;
        r = $urandom_range(99);
        if (r < 3)
            cmd = 3'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
        else if (r < 3 + ins_pct)
            cmd = $urandom_range(1) ? CMD_INS_BACK : CMD_INS_FRONT;
        else if (r < 18 + ins_pct)
            cmd = CMD_REM_VAL;
        else
            cmd = $urandom_range(1) ? CMD_REM_BACK : CMD_REM_FRONT;
        val = ($urandom_range(99) < 75) ? value_pool[$urandom_range(3)] : $urandom;
        send_word(cmd, val);
    endtask

    initial
    begin
        logic [31:0] dup_val;
        int          ins_pct;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= CMD_INS_FRONT;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        idle_en  = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty list, reserved command
        send_word(CMD_REM_FRONT, 32'hFFFF_FFFF);
        send_word(CMD_REM_BACK, 32'h0);
        send_word(CMD_REM_VAL, 32'h0);
        send_word(CMD_RSVD_LAST, 32'h1234_5678);

        // fill: duplicates pushed at the front so value removal takes the head
        dup_val = 32'h8000_0001;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i % 2 == 0)
                send_word(CMD_INS_FRONT, dup_val);
            else if (i == 1)
                send_word(CMD_INS_BACK, 32'h0);
            else if (i == 3)
                send_word(CMD_INS_BACK, 32'hFFFF_FFFF);
            else
                send_word(CMD_INS_BACK, $urandom);
        end
        send_word(CMD_INS_FRONT, 32'hAAAA_AAAA);
        send_word(CMD_INS_BACK, 32'h5555_5555);
        send_word(CMD_REM_VAL, dup_val);
        send_word(CMD_REM_VAL, 32'h7FFF_FFFE);
        send_word(CMD_REM_FRONT, 32'h0);
        send_word(CMD_REM_BACK, 32'h0);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            idle_en = !(p == 5 || p == 6);
            ins_pct = (p % 3 == 0) ? 60 : ((p % 3 == 1) ? 40 : 25);
            foreach (value_pool[k])
                value_pool[k] = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom;
            for (int n = 0; n < PHASE_WORDS; n++)
                send_random_word(ins_pct);
            drain_results();
        end

        idle_en = 1'b1;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.errors += sb.pending();
            $display("MISMATCH: %0d result words never arrived", sb.pending());
        end

        $display("Covered: %0d front ins, %0d back ins, %0d front rem, %0d back rem",
                 sb.cmd_count[CMD_INS_FRONT], sb.cmd_count[CMD_INS_BACK],
                 sb.cmd_count[CMD_REM_FRONT], sb.cmd_count[CMD_REM_BACK]);
        $display("  %0d value rem, %0d reserved", sb.cmd_count[CMD_REM_VAL],
                 sb.cmd_count[CMD_RSVD_FIRST] + sb.cmd_count[CMD_RSVD_FIRST + 3'd1]
                 + sb.cmd_count[CMD_RSVD_LAST]);
        $display("Full on insert %0d, empty on removal %0d, multi-entry value removals %0d",
                 sb.full_hits, sb.empty_hits, sb.multi_removals);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> bounded_list_deque_core.f
+incdir+sv
sv/bld_pkg.sv
sv/bld_cell.sv
sv/bounded_list_deque_core.sv
tb/bounded_list_deque_core_tb.sv
